/* hw/rtl/mep_pkg.sv */
// package for the modular exponentiation block: modulus, barrett and folding constants,
// sequencer states and multiplier tags
// no dependencies
`timescale 1ns / 1ps

package mep_pkg;

   localparam int unsigned EXP_BITS_DEF = 63;
   localparam int unsigned BASE_BITS = 63;
   localparam int unsigned EXP_PORT_BITS = 63;
   localparam int unsigned RES_BITS = 30;

   localparam logic [RES_BITS-1:0] PRIME_MOD = 30'd1000000007;
   localparam logic [31:0] PRIME_MOD_X2 = 32'd2000000014;

   // 2^30 mod p, scales a residue by one 30-bit base chunk
   localparam logic [RES_BITS-1:0] FOLD_MULT = 30'd73741817;

   // floor(2^60 / p), fits in 31 bits
   localparam logic [63:0] BARRETT_MU_FULL = 64'h1000_0000_0000_0000 / 64'd1000000007;
   localparam logic [30:0] BARRETT_MU = BARRETT_MU_FULL[30:0];

   typedef enum logic [1:0] {
      TAG_SQUARE = 2'd0,
      TAG_ACC    = 2'd1,
      TAG_FOLD   = 2'd2
   } mep_tag_type;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'd0,
      ST_REDUCE = 3'd1,
      ST_SQUARE = 3'd2,
      ST_MULT   = 3'd3,
      ST_DRAIN  = 3'd4,
      ST_FINISH = 3'd5,
      ST_FOLD   = 3'd6
   } mep_state_type;

endpackage

/* hw/rtl/modular_exponentiation_prime_top.sv */
// base^exponent mod 1000000007 by square and multiply on one shared modular multiplier
// the base is folded into a residue, then for each exponent bit up to the highest set one
// the accumulator takes the square where the bit is set and the square is updated
// one word in flight; idle again as the result loads, so the next is taken even while it waits
// synchronous active-high reset returns the sequencer to idle and empties all stages
// depends on mep_pkg, mep_reduce, mep_modmul
`timescale 1ns / 1ps

module modular_exponentiation_prime_top #(
   parameter int unsigned EXP_BITS = mep_pkg::EXP_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [mep_pkg::BASE_BITS-1:0]      req_base,
   input  logic [mep_pkg::EXP_PORT_BITS-1:0]  req_exponent,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [mep_pkg::RES_BITS-1:0]       rsp_power_mod
);
   import mep_pkg::*;

   mep_state_type       state_ff, state_in;
   logic [EXP_BITS-1:0] exp_ff, exp_in;
   logic [RES_BITS-1:0] sq_ff, sq_in;
   logic [RES_BITS-1:0] acc_ff, acc_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RES_BITS-1:0] rsp_pm_ff, rsp_pm_in;

   logic [63:0]         exp_ext;
   logic [EXP_BITS-1:0] exp_next;
   logic                red_load, red_shift, red_done;
   logic [RES_BITS-1:0] red_lead, red_residue;
   logic                mm_in_valid, mm_out_valid, mm_busy;
   mep_tag_type         mm_in_tag, mm_out_tag;
   logic [RES_BITS-1:0] mm_a, mm_b, mm_result;

   mep_reduce u_reduce (
      .clock   (clock),
      .reset   (reset),
      .load    (red_load),
      .value   (req_base),
      .shift   (red_shift),
      .partial (mm_result),
      .done    (red_done),
      .lead    (red_lead),
      .residue (red_residue)
   );

   mep_modmul u_modmul (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (mm_in_valid),
      .in_tag    (mm_in_tag),
      .op_a      (mm_a),
      .op_b      (mm_b),
      .out_valid (mm_out_valid),
      .out_tag   (mm_out_tag),
      .result    (mm_result),
      .busy      (mm_busy)
   );

   assign exp_ext  = {1'b0, req_exponent};
   assign exp_next = exp_ff >> 1;

   always_comb begin
      state_in     = state_ff;
      exp_in       = exp_ff;
      sq_in        = sq_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_pm_in    = rsp_pm_ff;
      red_load     = 1'b0;
      red_shift    = 1'b0;
      mm_in_valid  = 1'b0;
      mm_in_tag    = TAG_SQUARE;
      mm_a         = sq_ff;
      mm_b         = sq_ff;

      if (mm_out_valid) begin
         case (mm_out_tag)
            TAG_ACC: begin
               acc_in = mm_result;
            end
            TAG_FOLD: begin
               sq_in     = red_residue;
               red_shift = 1'b1;
            end
            default: begin
               sq_in = mm_result;
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               red_load = 1'b1;
               exp_in   = exp_ext[EXP_BITS-1:0];
               sq_in    = red_lead;
               acc_in   = RES_BITS'(1);
               state_in = ST_REDUCE;
            end
         end
         ST_REDUCE: begin
            mm_in_valid = 1'b1;
            mm_in_tag   = TAG_FOLD;
            mm_b        = FOLD_MULT;
            state_in    = ST_FOLD;
         end
         ST_FOLD: begin
            if (!mm_busy) begin
               if (!red_done) begin
                  state_in = ST_REDUCE;
               end else if (exp_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_SQUARE: begin
            // no square needed once the remaining exponent is spent
            if (exp_next != '0) begin
               mm_in_valid = 1'b1;
            end
            if (exp_ff[0]) begin
               state_in = ST_MULT;
            end else begin
               state_in = ST_DRAIN;
            end
         end
         ST_MULT: begin
            mm_in_valid = 1'b1;
            mm_in_tag   = TAG_ACC;
            mm_a        = acc_ff;
            state_in    = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (!mm_busy) begin
               exp_in = exp_next;
               if (exp_next == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_SQUARE;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pm_in    = acc_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      exp_ff    <= exp_in;
      sq_ff     <= sq_in;
      acc_ff    <= acc_in;
      rsp_pm_ff <= rsp_pm_in;
   end

   assign req_ready     = (state_ff == ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_power_mod = rsp_pm_ff;

endmodule

/* hw/rtl/mep_reduce.sv */
// base folding for the modular exponentiation block: holds the 63-bit base as 30-bit
// chunks and adds the next chunk to a scaled residue modulo the prime; uses mep_pkg
`timescale 1ns / 1ps

module mep_reduce (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           load,
   input  logic [mep_pkg::BASE_BITS-1:0]  value,
   input  logic                           shift,
   input  logic [mep_pkg::RES_BITS-1:0]   partial,
   output logic                           done,
   output logic [mep_pkg::RES_BITS-1:0]   lead,
   output logic [mep_pkg::RES_BITS-1:0]   residue
);
   import mep_pkg::*;

   logic [2*RES_BITS-1:0] chunk_ff, chunk_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic [RES_BITS+1:0]   sum;

   always_comb begin
      chunk_in = chunk_ff;
      cnt_in   = cnt_ff;
      if (load) begin
         chunk_in = value[2*RES_BITS-1:0];
         cnt_in   = 2'd2;
      end else if (shift) begin
         chunk_in = {chunk_ff[RES_BITS-1:0], {RES_BITS{1'b0}}};
         cnt_in   = cnt_ff - 2'd1;
      end
   end

   // residue plus a 30-bit chunk stays below 3p
   assign sum = {2'b00, partial} + {2'b00, chunk_ff[2*RES_BITS-1:RES_BITS]};

   always_comb begin
      if (sum >= PRIME_MOD_X2) begin
         residue = RES_BITS'(sum - PRIME_MOD_X2);
      end else if (sum >= {2'b00, PRIME_MOD}) begin
         residue = RES_BITS'(sum - {2'b00, PRIME_MOD});
      end else begin
         residue = sum[RES_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      chunk_ff <= chunk_in;
   end

   assign done = (cnt_ff == '0);
   assign lead = RES_BITS'(value[BASE_BITS-1:2*RES_BITS]);

endmodule

/* hw/rtl/mep_modmul.sv */
// four-stage pipelined modular multiplier, barrett reduction modulo the prime
// operands must be residues; uses mep_pkg
`timescale 1ns / 1ps

module mep_modmul (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  mep_pkg::mep_tag_type          in_tag,
   input  logic [mep_pkg::RES_BITS-1:0]  op_a,
   input  logic [mep_pkg::RES_BITS-1:0]  op_b,
   output logic                          out_valid,
   output mep_pkg::mep_tag_type          out_tag,
   output logic [mep_pkg::RES_BITS-1:0]  result,
   output logic                          busy
);
   import mep_pkg::*;

   logic [3:0]        valid_ff;
   mep_tag_type       tag1_ff, tag2_ff, tag3_ff, tag4_ff;
   logic [59:0]       prod_ff;
   logic [61:0]       mu_ff;
   logic [31:0]       lo2_ff, lo3_ff, qp_ff;
   logic [RES_BITS-1:0] res_ff, res_in;
   logic [31:0]       diff;

   // remainder estimate is below 3p, so two corrections at most
   always_comb begin
      diff = lo3_ff - qp_ff;
      if (diff >= PRIME_MOD_X2) begin
         res_in = RES_BITS'(diff - PRIME_MOD_X2);
      end else if (diff >= {2'b00, PRIME_MOD}) begin
         res_in = RES_BITS'(diff - {2'b00, PRIME_MOD});
      end else begin
         res_in = diff[RES_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= {valid_ff[2:0], in_valid};
      end
      tag1_ff <= in_tag;
      tag2_ff <= tag1_ff;
      tag3_ff <= tag2_ff;
      tag4_ff <= tag3_ff;
      prod_ff <= 60'(op_a) * 60'(op_b);
      mu_ff   <= 62'(prod_ff[59:29]) * 62'(BARRETT_MU);
      lo2_ff  <= prod_ff[31:0];
      qp_ff   <= 32'(mu_ff[61:31]) * 32'(PRIME_MOD);
      lo3_ff  <= lo2_ff;
      res_ff  <= res_in;
   end

   assign out_valid = valid_ff[3];
   assign out_tag   = tag4_ff;
   assign result    = res_ff;
   assign busy      = |valid_ff;

endmodule
